// ===== src/gaps_pkg.sv =====
`default_nettype none
package gaps_pkg;

  localparam int GRID_W = 64;
  localparam int GRID_H = 16;
  localparam int NCELLS = GRID_W * GRID_H;
  localparam int XW = 6;
  localparam int YW = 4;
  localparam int AW = XW + YW;
  localparam int GW = 14;
  localparam int FW = 15;
  localparam int HW = 10;
  localparam int CW = 11;

  localparam logic [GW-1:0] COST_STRAIGHT = GW'(10);
  localparam logic [GW-1:0] COST_DIAG = GW'(14);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_NOPATH = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [1:0] KIND_WALL = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_EXIT = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic CFG_GOAL_X = 1'b0;
  localparam logic CFG_GOAL_Y = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MAPCLR,
    OP_LOAD,
    OP_RD_ISSUE,
    OP_RD_EMIT,
    OP_SRCH_INIT,
    OP_NCLR,
    OP_START_WR,
    OP_SCAN,
    OP_NB_ISSUE,
    OP_NB_EVAL,
    OP_CLOSE,
    OP_WALK_INIT,
    OP_WALK,
    OP_WALK_PAR,
    OP_EMIT_FOUND,
    OP_EMIT_NOPATH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic found;
    logic h_busy;
    logic nb_inr;
    logic nb_exit;
    logic d_last;
    logic walk_end;
  } stat_t;

  typedef struct packed {
    logic [GW-1:0] g;
    logic [FW-1:0] f;
    logic [2:0]    dir;
    logic          open;
    logic          closed;
  } node_t;

  // neighbor order: dx -1,-1,-1,0,0,1,1,1 ; dy -1,0,1,-1,1,-1,0,1
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    if (d < 3'd3) r = 2'b11;
    else if (d < 3'd5) r = 2'b00;
    else r = 2'b01;
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    unique case (d)
      3'd0, 3'd3, 3'd5: r = 2'b11;
      3'd1, 3'd6: r = 2'b00;
      default: r = 2'b01;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/gaps_heur.sv =====
`default_nettype none
// 10*floor(sqrt(dx^2+dy^2)), one root bit per cycle
module gaps_heur import gaps_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  input  wire logic [YW-1:0] y,
  input  wire logic [XW-1:0] gx,
  input  wire logic [YW-1:0] gy,
  output logic               busy,
  output logic [HW-1:0]      h
);

  logic [12:0] v;
  logic [12:0] r;
  logic [12:0] bitp;
  logic [XW-1:0] adx;
  logic [YW-1:0] ady;
  logic [12:0] sum;
  logic [12:0] trial;

  always_comb begin
    adx = (x >= gx) ? (x - gx) : (gx - x);
    ady = (y >= gy) ? (y - gy) : (gy - y);
    sum = 13'(adx * adx) + 13'(ady * ady);
    trial = r + bitp;
    busy = |bitp;
    h = HW'({r[6:0], 3'b000}) + HW'({r[6:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitp <= '0;
    end else if (start) begin
      v <= sum;
      r <= '0;
      bitp <= 13'h1000;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitp;
      end else begin
        r <= r >> 1;
      end
      bitp <= bitp >> 2;
    end
  end

endmodule
`default_nettype wire

// ===== src/gaps_dp.sv =====
`default_nettype none
module gaps_dp import gaps_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          cmd,
  output stat_t              stat,
  input  wire logic [XW-1:0] cell_x,
  input  wire logic [YW-1:0] cell_y,
  input  wire logic [1:0]    cell_kind,
  input  wire logic [XW-1:0] goal_x,
  input  wire logic [YW-1:0] goal_y,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [XW-1:0]      out_x,
  output logic [YW-1:0]      out_y,
  output logic               out_last,
  output logic [CW-1:0]      out_len
);

  logic [1:0]    map_mem [NCELLS];
  node_t         node_mem [NCELLS];
  logic [AW-1:0] stack_mem [NCELLS];

  logic [1:0]    map_rd;
  node_t         node_rd;
  logic [AW-1:0] stack_rd;

  logic [AW-1:0] cnt;
  logic [AW-1:0] start_idx;
  logic          found;
  logic [AW-1:0] q_idx;
  logic [GW-1:0] q_g;
  logic [FW-1:0] q_f;
  logic [2:0]    q_dir;
  logic          scan_v;
  logic [AW-1:0] scan_idx;
  logic [2:0]    d;
  logic [AW-1:0] n_idx;
  logic          n_inr;
  logic [GW-1:0] n_g;
  logic [AW-1:0] cur;
  logic [AW-1:0] j;
  logic [CW-1:0] path_count;
  logic [CW-1:0] cursor;
  logic [XW-1:0] path_gx;
  logic [YW-1:0] path_gy;

  logic          heur_start;
  logic          heur_busy;
  logic [HW-1:0] heur_h;
  logic [XW-1:0] heur_x;
  logic [YW-1:0] heur_y;

  // neighbor coordinates
  logic [1:0]    ndx, ndy, pdx, pdy;
  logic [XW:0]   nx;
  logic [YW:0]   ny;
  logic          n_ok;
  logic [FW-1:0] n_f;
  logic          n_skip;
  logic [XW:0]   px;
  logic [YW:0]   py;
  logic [AW-1:0] parent;
  logic          walk_end;
  logic [CW-1:0] rd_addr;

  // memory port controls
  logic          map_we, map_re, node_we, node_re;
  logic [AW-1:0] map_waddr, map_raddr, node_waddr, node_raddr;
  logic [1:0]    map_wdata;
  node_t         node_wdata;

  gaps_heur u_heur (
    .clk  (clk),
    .rst  (rst),
    .start(heur_start),
    .x    (heur_x),
    .y    (heur_y),
    .gx   (goal_x),
    .gy   (goal_y),
    .busy (heur_busy),
    .h    (heur_h)
  );

  always_comb begin
    ndx = dir_dx(d);
    ndy = dir_dy(d);
    nx = {1'b0, q_idx[XW-1:0]} + {{(XW-1){ndx[1]}}, ndx};
    ny = {1'b0, q_idx[AW-1:XW]} + {{(YW-1){ndy[1]}}, ndy};
    n_ok = !nx[XW] && (nx[XW-1:0] != '0) && !ny[YW] && (ny[YW-1:0] != '0);

    n_f = FW'(n_g) + FW'(heur_h);
    n_skip = (node_rd.open || node_rd.closed) && (node_rd.f <= n_f);

    pdx = dir_dx(node_rd.dir);
    pdy = dir_dy(node_rd.dir);
    px = {1'b0, cur[XW-1:0]} - {{(XW-1){pdx[1]}}, pdx};
    py = {1'b0, cur[AW-1:XW]} - {{(YW-1){pdy[1]}}, pdy};
    parent = (px[XW] || py[YW]) ? '0 : {py[YW-1:0], px[XW-1:0]};

    walk_end = (cur == start_idx) || (&j);
    rd_addr = path_count - CW'(2) - cursor;

    heur_start = (cmd.op == OP_SRCH_INIT) || (cmd.op == OP_NB_ISSUE);
    heur_x = (cmd.op == OP_SRCH_INIT) ? cell_x : nx[XW-1:0];
    heur_y = (cmd.op == OP_SRCH_INIT) ? cell_y : ny[YW-1:0];

    map_we = 1'b0;
    map_waddr = cnt;
    map_wdata = KIND_WALL;
    map_re = (cmd.op == OP_NB_ISSUE);
    map_raddr = {ny[YW-1:0], nx[XW-1:0]};
    node_we = 1'b0;
    node_waddr = cnt;
    node_wdata = '0;
    node_re = 1'b0;
    node_raddr = cnt;
    unique case (cmd.op)
      OP_MAPCLR: map_we = 1'b1;
      OP_LOAD: begin
        map_we = 1'b1;
        map_waddr = {cell_y, cell_x};
        map_wdata = (cell_kind == KIND_BAD) ? KIND_WALL : cell_kind;
      end
      OP_NCLR: node_we = 1'b1;
      OP_START_WR: begin
        node_we = 1'b1;
        node_waddr = start_idx;
        node_wdata = '{g: '0, f: FW'(heur_h), dir: '0, open: 1'b1, closed: 1'b0};
      end
      OP_SCAN: node_re = 1'b1;
      OP_NB_ISSUE: begin
        node_re = 1'b1;
        node_raddr = {ny[YW-1:0], nx[XW-1:0]};
      end
      OP_NB_EVAL: begin
        node_we = n_inr && (map_rd == KIND_FREE) && !n_skip;
        node_waddr = n_idx;
        node_wdata = '{g: n_g, f: n_f, dir: d, open: 1'b1, closed: 1'b0};
      end
      OP_CLOSE: begin
        node_we = 1'b1;
        node_waddr = q_idx;
        node_wdata = '{g: q_g, f: q_f, dir: q_dir, open: 1'b0, closed: 1'b1};
      end
      OP_WALK: begin
        node_re = 1'b1;
        node_raddr = cur;
      end
      default: ;
    endcase

    stat.out_free = !out_valid || out_ready;
    stat.cnt_last = &cnt;
    stat.found = found;
    stat.h_busy = heur_busy;
    stat.nb_inr = n_inr;
    stat.nb_exit = (map_rd == KIND_EXIT);
    stat.d_last = (d == 3'd7);
    stat.walk_end = walk_end;
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WALK) stack_mem[j] <= cur;
    if (cmd.op == OP_RD_ISSUE) stack_rd <= stack_mem[rd_addr[AW-1:0]];
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      found <= 1'b0;
      scan_v <= 1'b0;
      d <= '0;
      path_count <= '0;
      cursor <= '0;
      out_valid <= 1'b0;
    end else begin
      scan_v <= (cmd.op == OP_SCAN);
      scan_idx <= cnt;
      if (out_valid && out_ready) out_valid <= 1'b0;

      // least f, first index wins ties
      if (scan_v && node_rd.open && (!found || node_rd.f < q_f)) begin
        found <= 1'b1;
        q_idx <= scan_idx;
        q_g <= node_rd.g;
        q_f <= node_rd.f;
        q_dir <= node_rd.dir;
      end

      unique case (cmd.op)
        OP_MAPCLR, OP_NCLR, OP_SCAN: cnt <= cnt + 1'b1;
        OP_LOAD: begin
          out_valid <= 1'b1;
          out_status <= ST_STORED;
          out_x <= '0;
          out_y <= '0;
          out_last <= 1'b0;
          out_len <= '0;
        end
        OP_RD_EMIT: begin
          out_valid <= 1'b1;
          out_len <= path_count;
          out_last <= 1'b0;
          out_x <= '0;
          out_y <= '0;
          if (cursor < path_count) begin
            out_status <= ST_STEP;
            cursor <= cursor + 1'b1;
            if (cursor == path_count - 1'b1) begin
              out_x <= path_gx;
              out_y <= path_gy;
              out_last <= 1'b1;
            end else begin
              out_x <= stack_rd[XW-1:0];
              out_y <= stack_rd[AW-1:XW];
            end
          end else begin
            out_status <= ST_EMPTY;
          end
        end
        OP_SRCH_INIT: begin
          start_idx <= {cell_y, cell_x};
          path_count <= '0;
          cursor <= '0;
        end
        OP_START_WR: found <= 1'b0;
        OP_NB_ISSUE: begin
          n_idx <= {ny[YW-1:0], nx[XW-1:0]};
          n_inr <= n_ok;
          n_g <= q_g + ((ndx != 2'b00 && ndy != 2'b00) ? COST_DIAG : COST_STRAIGHT);
        end
        OP_NB_EVAL: d <= d + 1'b1;
        OP_CLOSE: found <= 1'b0;
        OP_WALK_INIT: begin
          cur <= q_idx;
          j <= '0;
          d <= '0;
          found <= 1'b0;
        end
        OP_WALK: begin
          j <= j + 1'b1;
          if (walk_end) begin
            path_count <= CW'(j) + CW'(2);
            path_gx <= goal_x;
            path_gy <= goal_y;
          end
        end
        OP_WALK_PAR: cur <= parent;
        OP_EMIT_FOUND: begin
          out_valid <= 1'b1;
          out_status <= ST_FOUND;
          out_x <= '0;
          out_y <= '0;
          out_last <= 1'b0;
          out_len <= path_count;
        end
        OP_EMIT_NOPATH: begin
          out_valid <= 1'b1;
          out_status <= ST_NOPATH;
          out_x <= '0;
          out_y <= '0;
          out_last <= 1'b0;
          out_len <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/gaps_ctrl.sv =====
`default_nettype none
module gaps_ctrl import gaps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_mode,
  output logic            in_ready,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_NCLR,
    S_START,
    S_SCAN,
    S_SCAN_END,
    S_SCAN_CHK,
    S_NB,
    S_NB_WAIT,
    S_CLOSE,
    S_WALK,
    S_WALK_PAR,
    S_FOUND,
    S_NOPATH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    in_ready = (state == S_IDLE) && stat.out_free;
    unique case (state)
      S_INIT: begin
        cmd.op = OP_MAPCLR;
        if (stat.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          priority case (in_mode)
            MODE_LOAD: cmd.op = OP_LOAD;
            MODE_READ: begin
              cmd.op = OP_RD_ISSUE;
              state_next = S_RD;
            end
            MODE_SEARCH: begin
              cmd.op = OP_SRCH_INIT;
              state_next = S_NCLR;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (stat.out_free) begin
          cmd.op = OP_RD_EMIT;
          state_next = S_IDLE;
        end
      end
      S_NCLR: begin
        cmd.op = OP_NCLR;
        if (stat.cnt_last) state_next = S_START;
      end
      S_START: begin
        if (!stat.h_busy) begin
          cmd.op = OP_START_WR;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.cnt_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = stat.found ? S_NB : S_NOPATH;
      S_NB: begin
        cmd.op = OP_NB_ISSUE;
        state_next = S_NB_WAIT;
      end
      S_NB_WAIT: begin
        if (!stat.h_busy) begin
          if (stat.nb_inr && stat.nb_exit) begin
            cmd.op = OP_WALK_INIT;
            state_next = S_WALK;
          end else begin
            cmd.op = OP_NB_EVAL;
            state_next = stat.d_last ? S_CLOSE : S_NB;
          end
        end
      end
      S_CLOSE: begin
        cmd.op = OP_CLOSE;
        state_next = S_SCAN;
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        state_next = stat.walk_end ? S_FOUND : S_WALK_PAR;
      end
      S_WALK_PAR: begin
        cmd.op = OP_WALK_PAR;
        state_next = S_WALK;
      end
      S_FOUND: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_NOPATH: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT_NOPATH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/grid_a_star_path_search_unit.sv =====
// 8-connected A* search over a 64 x 16 cell map. Items on the input stream
// load a cell (wall, free, exit), start a search from a cell, or read the
// next step of the last path found; each gives exactly one result item, and
// a mode of three is dropped. After reset the unit sweeps the map to walls
// before it takes any item (goal writes are taken at all times). A path read
// fetches the step from the path store before it answers. A search runs on a
// single-port node memory: a sweep to clear the open/closed marks, then per
// expansion a scan of all cells for the least-f open cell and, per neighbor,
// an issue and a wait on the shared root unit, and finally a walk and a
// parent step per cell of the parent walk. Results sit in an output register,
// so a result waiting downstream does not stall a finished pass.
`default_nettype none
module grid_a_star_path_search_unit import gaps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // cell_x[5:0], cell_y[9:6], cell_kind[11:10]
  input  wire logic [1:0]  s_tuser,  // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // step_x[5:0], step_y[9:6], path_length[20:10]
  output logic [2:0]       m_tuser,  // status[2:0]
  output logic             m_tlast,  // last_step
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic [XW-1:0] goal_x;
  logic [YW-1:0] goal_y;
  cmd_t          cmd;
  stat_t         stat;
  logic [XW-1:0] out_x;
  logic [YW-1:0] out_y;
  logic [CW-1:0] out_len;

  // goal registers; indexes past the list are dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
    end else if (cfg_valid && !cfg_index[1]) begin
      unique case (cfg_index[0])
        CFG_GOAL_X: goal_x <= cfg_data;
        CFG_GOAL_Y: goal_y <= cfg_data[YW-1:0];
        default: ;
      endcase
    end
  end

  gaps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_mode (s_tuser),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  gaps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cell_x    (s_tdata[5:0]),
    .cell_y    (s_tdata[9:6]),
    .cell_kind (s_tdata[11:10]),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_status(m_tuser),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_last  (m_tlast),
    .out_len   (out_len)
  );

  assign m_tdata = {3'b000, out_len, out_y, out_x};

  // an item is only taken when the result register can hold its answer
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
    else $error("item accepted with result register blocked");

  // only path steps carry the last-step flag
  a_last_is_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == ST_STEP))
    else $error("last_step set on a non-step result");

  // a found path holds at least the start and the goal
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FOUND) |-> (out_len >= CW'(2)))
    else $error("found path shorter than two steps");

endmodule
`default_nettype wire

// ===== tb/grid_a_star_path_search_unit_test.sv =====
`timescale 1ns / 100ps
module grid_a_star_path_search_unit_test;
  import gaps_pkg::*;

  // mode three is dropped by the unit and gives no result item
  localparam logic [1:0] MODE_DROP = 2'd3;
  localparam logic [1:0] CFG_X_IDX = {1'b0, CFG_GOAL_X};
  localparam logic [1:0] CFG_Y_IDX = {1'b0, CFG_GOAL_Y};
  localparam int DDX[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  localparam int DDY[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  grid_a_star_path_search_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  sx;
    logic [3:0]  sy;
    logic        last;
    logic [10:0] plen;
  } step_res_t;

  // directed row; when typed, status and path_length are given and the rest is zero
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  x;
    logic [3:0]  y;
    logic [1:0]  kind;
    logic        typed;
    logic [2:0]  st;
    logic [10:0] plen;
  } row_t;

  localparam int NROWS = 24;
  localparam row_t ROWS[NROWS] = '{
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b1, ST_EMPTY,  11'd0},
    '{MODE_LOAD,   6'd63, 4'd15, KIND_EXIT, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd0,  4'd0,  KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd2,  4'd2,  KIND_BAD,  1'b1, ST_STORED, 11'd0},
    '{MODE_SEARCH, 6'd0,  4'd0,  KIND_WALL, 1'b1, ST_NOPATH, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b1, ST_EMPTY,  11'd0},
    '{MODE_LOAD,   6'd1,  4'd1,  KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd2,  4'd1,  KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd3,  4'd1,  KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd3,  4'd2,  KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd5,  4'd3,  KIND_EXIT, 1'b1, ST_STORED, 11'd0},
    '{MODE_SEARCH, 6'd1,  4'd1,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_DROP,   6'd7,  4'd7,  KIND_BAD,  1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_LOAD,   6'd62, 4'd14, KIND_FREE, 1'b1, ST_STORED, 11'd0},
    '{MODE_SEARCH, 6'd62, 4'd14, KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    '{MODE_READ,   6'd0,  4'd0,  KIND_WALL, 1'b0, ST_STORED, 11'd0},
    // search from a wall cell: start kind is not checked, all neighbors walls
    '{MODE_SEARCH, 6'd10, 4'd10, KIND_WALL, 1'b1, ST_NOPATH, 11'd0}
  };

  // ---------------------------------------------------------------------------
  // Path search predictor: own copy of map, node store, path and goal
  // ---------------------------------------------------------------------------
  logic [1:0] map_kind[NCELLS];
  int         node_g[NCELLS];
  int         node_f[NCELLS];
  int         node_dir[NCELLS];
  bit         is_open[NCELLS];
  bit         is_closed[NCELLS];
  int         path_cells[NCELLS + 1];
  int         rd_ptr;
  int         path_len;
  int         goal_col;
  int         goal_row;

  step_res_t  expected_steps[$];
  bit         failed = 1'b0;

  function automatic int int_sqrt(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int dist_cost(input int x, input int y);
    int dx, dy;
    dx = x - goal_col;
    dy = y - goal_row;
    return 10 * int_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic int parent_cell(input int c);
    int x, y;
    x = c % GRID_W - DDX[node_dir[c]];
    y = c / GRID_W - DDY[node_dir[c]];
    if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 0;
    return y * GRID_W + x;
  endfunction

  function automatic void trace_path(input int q, input int s);
    int len, cur;
    len = 0;
    cur = q;
    forever begin
      len++;
      if (cur == s || len >= NCELLS) break;
      cur = parent_cell(cur);
    end
    cur = q;
    for (int k = len; k > 0; k--) begin
      path_cells[k - 1] = cur;
      cur = parent_cell(cur);
    end
    path_cells[len] = goal_row * GRID_W + goal_col;
    path_len = len + 1;
  endfunction

  function automatic logic [2:0] astar(input int sx, input int sy);
    int s, q, nx, ny, n, g, f;
    bit got;
    for (int i = 0; i < NCELLS; i++) begin
      is_open[i] = 0;
      is_closed[i] = 0;
    end
    path_len = 0;
    rd_ptr = 0;
    s = sy * GRID_W + sx;
    node_g[s] = 0;
    node_f[s] = dist_cost(sx, sy);
    is_open[s] = 1;
    forever begin
      got = 0;
      q = 0;
      for (int i = 0; i < NCELLS; i++)
        if (is_open[i] && (!got || node_f[i] < node_f[q])) begin
          q = i;
          got = 1;
        end
      if (!got) return ST_NOPATH;
      is_open[q] = 0;
      for (int d = 0; d < 8; d++) begin
        nx = q % GRID_W + DDX[d];
        ny = q / GRID_W + DDY[d];
        if (nx < 1 || nx > GRID_W - 1 || ny < 1 || ny > GRID_H - 1) continue;
        n = ny * GRID_W + nx;
        if (map_kind[n] == KIND_EXIT) begin
          trace_path(q, s);
          return ST_FOUND;
        end
        if (map_kind[n] != KIND_FREE) continue;
        g = node_g[q] + ((DDX[d] != 0 && DDY[d] != 0) ? 14 : 10);
        f = g + dist_cost(nx, ny);
        // skip when an open or closed entry already has f at or below the new f
        if ((is_open[n] || is_closed[n]) && node_f[n] <= f) continue;
        node_g[n] = g;
        node_f[n] = f;
        node_dir[n] = d;
        is_open[n] = 1;
        is_closed[n] = 0;
      end
      is_closed[q] = 1;
    end
  endfunction

  function automatic step_res_t predict_step(input logic [1:0] mode, input logic [5:0] x,
                                             input logic [3:0] y, input logic [1:0] kind);
    step_res_t r;
    int e;
    r = '0;
    case (mode)
      MODE_LOAD: begin
        map_kind[y * GRID_W + x] = (kind == KIND_BAD) ? KIND_WALL : kind;
      end
      MODE_SEARCH: begin
        r.status = astar(int'(x), int'(y));
        r.plen = 11'(path_len);
      end
      default: begin
        r.plen = 11'(path_len);
        if (rd_ptr < path_len) begin
          e = path_cells[rd_ptr];
          r.status = ST_STEP;
          r.sx = 6'(e % GRID_W);
          r.sy = 4'(e / GRID_W);
          r.last = (rd_ptr + 1 == path_len);
          rd_ptr++;
        end else begin
          r.status = ST_EMPTY;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one input item; on acceptance predict its result (or a typed one).
  task automatic send_item(input logic [1:0] mode, input logic [5:0] x, input logic [3:0] y,
                           input logic [1:0] kind, input bit typed, input step_res_t fixed);
    int gap;
    step_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, kind, y, x};
    do @(posedge clk); while (!s_tready);
    if (mode != MODE_DROP) begin
      r = predict_step(mode, x, y, kind);
      expected_steps.push_back(typed ? fixed : r);
    end
  endtask

  task automatic write_goal(input logic [5:0] col, input logic [3:0] row);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_X_IDX;
    cfg_data <= col;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_Y_IDX;
    cfg_data <= {2'b0, row};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    goal_col = int'(col);
    goal_row = int'(row);
  endtask

  // Drain: all results in, then a short pause covering a dropped item.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random item: mostly loads and searches inside a small window so the
  // searches stay short, plus reads, drops and loads anywhere on the grid.
  task automatic random_item();
    int p;
    logic [5:0] x;
    logic [3:0] y;
    p = $urandom_range(99);
    x = 6'($urandom_range(7, 0));
    y = 4'($urandom_range(5, 0));
    if (p < 45) begin
      send_item(MODE_LOAD, x, y, 2'($urandom_range(3)), 1'b0, '0);
    end else if (p < 58) begin
      send_item(MODE_LOAD, 6'($urandom_range(63)), 4'($urandom_range(15)),
                2'($urandom_range(3)), 1'b0, '0);
    end else if (p < 64) begin
      send_item(MODE_SEARCH, x, y, 2'($urandom_range(3)), 1'b0, '0);
    end else if (p < 95) begin
      send_item(MODE_READ, 6'($urandom_range(63)), 4'($urandom_range(15)),
                2'($urandom_range(3)), 1'b0, '0);
    end else begin
      send_item(MODE_DROP, 6'($urandom_range(63)), 4'($urandom_range(15)),
                2'($urandom_range(3)), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    step_res_t fixed;
    for (int i = 0; i < NCELLS; i++) map_kind[i] = KIND_WALL;
    rd_ptr = 0;
    path_len = 0;
    goal_col = 0;
    goal_row = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_goal(6'd4, 4'd2);
    foreach (ROWS[i]) begin
      fixed = '0;
      fixed.status = ROWS[i].st;
      fixed.plen = ROWS[i].plen;
      send_item(ROWS[i].mode, ROWS[i].x, ROWS[i].y, ROWS[i].kind, ROWS[i].typed, fixed);
    end
    drain();

    // random phases, goal at both corners and then random spots
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_goal(6'd0, 4'd0);
        1: write_goal(6'd63, 4'd15);
        default: write_goal(6'($urandom_range(63)), 4'($urandom_range(15)));
      endcase
      repeat (100) random_item();
      drain();
    end

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, field-by-field compare
  // ---------------------------------------------------------------------------
  initial begin
    int stall, n_seen, p;
    step_res_t want;
    stall = 0;
    n_seen = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        n_seen++;
        if (expected_steps.size() == 0) begin
          $error("result item with nothing expected: status %0d", m_tuser);
          failed = 1'b1;
        end else begin
          want = expected_steps.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            failed = 1'b1;
          end
          if (m_tdata[5:0] !== want.sx) begin
            $error("step_x: expected %0d, got %0d", want.sx, m_tdata[5:0]);
            failed = 1'b1;
          end
          if (m_tdata[9:6] !== want.sy) begin
            $error("step_y: expected %0d, got %0d", want.sy, m_tdata[9:6]);
            failed = 1'b1;
          end
          if (m_tlast !== want.last) begin
            $error("last_step: expected %0d, got %0d", want.last, m_tlast);
            failed = 1'b1;
          end
          if (m_tdata[20:10] !== want.plen) begin
            $error("path_length: expected %0d, got %0d", want.plen, m_tdata[20:10]);
            failed = 1'b1;
          end
        end
        // long hold-off once, early in the random loads, to back up the input
        if (n_seen == 60) stall = 300;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        p = $urandom_range(99);
        if (p < 75) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall = (p < 97) ? $urandom_range(3, 0) : $urandom_range(40, 10);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
